/* rtl/akltf_pkg.sv */
// ----------------------------------------------------------------------------
// akltf_pkg
// Types, widths and codes shared by the Akl-Toussaint point filter.
// ----------------------------------------------------------------------------
package akltf_pkg;

    // Coordinate width and the widths that follow from it
    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;

    // Item actions
    typedef enum logic [1:0] {
        ACT_SCAN   = 2'd0,
        ACT_FILTER = 2'd1,
        ACT_FINISH = 2'd2
    } t_action;

    // Slots of the extreme point store, also the finish output order
    localparam logic [1:0] EXT_MINX = 2'd0;
    localparam logic [1:0] EXT_MAXX = 2'd1;
    localparam logic [1:0] EXT_MINY = 2'd2;
    localparam logic [1:0] EXT_MAXY = 2'd3;
    localparam logic [1:0] EXT_LAST = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    // Quadrilateral sides walk minx -> maxy -> maxx -> miny -> minx
    function automatic logic [1:0] side_start(input logic [1:0] k);
        logic [1:0] s;
        case (k)
            2'd0:    s = EXT_MINX;
            2'd1:    s = EXT_MAXY;
            2'd2:    s = EXT_MAXX;
            default: s = EXT_MINY;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] side_end(input logic [1:0] k);
        logic [1:0] s;
        case (k)
            2'd0:    s = EXT_MAXY;
            2'd1:    s = EXT_MAXX;
            2'd2:    s = EXT_MINY;
            default: s = EXT_MINX;
        endcase
        return s;
    endfunction

endpackage

/* rtl/akl_toussaint_point_filter_core.sv */
// Path: a filter result passes stage A, stage B and the result register; a
// finish presents its four extremes one per output transfer from there on.
// Throughput: one input item per cycle while the output does not stall; finish
// holds the single result register for four transfers and serializes them.
// Reset: synchronous, active low; clears extremes, the seen flag and all
// stage valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// akl_toussaint_point_filter_core
// Tracks the four extreme points of a scanned set, drops filtered points that
// fall inside or on their quadrilateral, and emits the extremes on finish.
// ----------------------------------------------------------------------------
module akl_toussaint_point_filter_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_action,
    input  logic signed [akltf_pkg::COORD_BITS-1:0] i_px,
    input  logic signed [akltf_pkg::COORD_BITS-1:0] i_py,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [akltf_pkg::COORD_BITS-1:0] o_qx,
    output logic signed [akltf_pkg::COORD_BITS-1:0] o_qy,
    output logic                                  o_is_extreme,
    output logic                                  o_last_result
);
    import akltf_pkg::*;

    // Extreme point store
    t_point r_ext [4];
    t_point n_ext [4];
    logic   r_seen_any;
    logic   n_seen_any;

    // Stage A: differences against the quadrilateral
    logic                        r_a_valid;
    logic                        r_a_fin;
    t_point                      r_a_pt;
    t_point                      r_a_ext [4];
    logic signed [DIFF_BITS-1:0] r_a_dsx [4];
    logic signed [DIFF_BITS-1:0] r_a_dsy [4];
    logic signed [DIFF_BITS-1:0] r_a_dpx [4];
    logic signed [DIFF_BITS-1:0] r_a_dpy [4];
    logic signed [DIFF_BITS-1:0] n_a_dsx [4];
    logic signed [DIFF_BITS-1:0] n_a_dsy [4];
    logic signed [DIFF_BITS-1:0] n_a_dpx [4];
    logic signed [DIFF_BITS-1:0] n_a_dpy [4];

    // Stage B: cross product terms
    logic                        r_b_valid;
    logic                        r_b_fin;
    t_point                      r_b_pt;
    t_point                      r_b_ext [4];
    logic signed [PROD_BITS-1:0] r_b_lhs [4];
    logic signed [PROD_BITS-1:0] r_b_rhs [4];
    logic signed [PROD_BITS-1:0] n_b_lhs [4];
    logic signed [PROD_BITS-1:0] n_b_rhs [4];

    // Result register
    logic       r_o_valid;
    logic       r_o_fin;
    logic [1:0] r_o_idx;
    t_point     r_o_pt;
    t_point     r_o_ext [4];

    // Handshake and flow
    logic   in_xfer;
    logic   load_a;
    logic   a_free;
    logic   b_free;
    logic   o_load_ok;
    logic   out_xfer;
    logic   o_last_beat;
    logic   inside_all;
    logic   emit_b;
    t_point in_pt;
    t_point o_pt;

    assign in_pt.x = i_px;
    assign in_pt.y = i_py;

    // Ready chain from the result register back to the input
    assign out_xfer    = r_o_valid && i_out_ready;
    assign o_last_beat = !r_o_fin || (r_o_idx == EXT_LAST);
    assign o_load_ok   = !r_o_valid || (out_xfer && o_last_beat);
    assign b_free      = !r_b_valid || o_load_ok;
    assign a_free      = !r_a_valid || b_free;
    assign o_in_ready  = a_free;
    assign in_xfer     = i_in_valid && o_in_ready;

    // Only filter items and finish with a seeded set travel the pipeline
    assign load_a = in_xfer && ((i_action == ACT_FILTER) ||
                                ((i_action == ACT_FINISH) && r_seen_any));

    // Update extremes on scan, clear on finish
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_ext[i] = r_ext[i];
        end
        n_seen_any = r_seen_any;
        if (in_xfer && (i_action == ACT_SCAN)) begin
            if (!r_seen_any) begin
                for (int i = 0; i < 4; i++) begin
                    n_ext[i] = in_pt;
                end
                n_seen_any = 1'b1;
            end else begin
                if (i_px < r_ext[EXT_MINX].x) n_ext[EXT_MINX] = in_pt;
                if (i_px > r_ext[EXT_MAXX].x) n_ext[EXT_MAXX] = in_pt;
                if (i_py < r_ext[EXT_MINY].y) n_ext[EXT_MINY] = in_pt;
                if (i_py > r_ext[EXT_MAXY].y) n_ext[EXT_MAXY] = in_pt;
            end
        end else if (in_xfer && (i_action == ACT_FINISH)) begin
            for (int i = 0; i < 4; i++) begin
                n_ext[i] = '0;
            end
            n_seen_any = 1'b0;
        end
    end

    // Side vectors and point offsets, one per quadrilateral side
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_a_dsx[k] = {r_ext[side_end(2'(k))].x[COORD_BITS-1], r_ext[side_end(2'(k))].x}
                       - {r_ext[side_start(2'(k))].x[COORD_BITS-1],
                          r_ext[side_start(2'(k))].x};
            n_a_dsy[k] = {r_ext[side_end(2'(k))].y[COORD_BITS-1], r_ext[side_end(2'(k))].y}
                       - {r_ext[side_start(2'(k))].y[COORD_BITS-1],
                          r_ext[side_start(2'(k))].y};
            n_a_dpx[k] = {i_px[COORD_BITS-1], i_px}
                       - {r_ext[side_start(2'(k))].x[COORD_BITS-1],
                          r_ext[side_start(2'(k))].x};
            n_a_dpy[k] = {i_py[COORD_BITS-1], i_py}
                       - {r_ext[side_start(2'(k))].y[COORD_BITS-1],
                          r_ext[side_start(2'(k))].y};
        end
    end

    // Cross product terms, exact in the doubled width
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_b_lhs[k] = PROD_BITS'(r_a_dsy[k]) * PROD_BITS'(r_a_dpx[k]);
            n_b_rhs[k] = PROD_BITS'(r_a_dsx[k]) * PROD_BITS'(r_a_dpy[k]);
        end
    end

    // Inside or on every side: drop the point
    always_comb begin
        inside_all = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (r_b_lhs[k] < r_b_rhs[k]) inside_all = 1'b0;
        end
    end
    assign emit_b = r_b_valid && (r_b_fin || !inside_all);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_ext[i] <= '0;
            end
            r_seen_any <= 1'b0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_o_idx    <= '0;
        end else begin
            for (int i = 0; i < 4; i++) begin
                r_ext[i] <= n_ext[i];
            end
            r_seen_any <= n_seen_any;
            if (a_free) begin
                r_a_valid <= load_a;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (o_load_ok) begin
                r_o_valid <= emit_b;
                r_o_idx   <= '0;
            end else if (out_xfer) begin
                r_o_idx <= r_o_idx + 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_fin <= (i_action == ACT_FINISH);
            r_a_pt  <= in_pt;
            for (int k = 0; k < 4; k++) begin
                r_a_ext[k] <= r_ext[k];
                r_a_dsx[k] <= n_a_dsx[k];
                r_a_dsy[k] <= n_a_dsy[k];
                r_a_dpx[k] <= n_a_dpx[k];
                r_a_dpy[k] <= n_a_dpy[k];
            end
        end
        if (b_free) begin
            r_b_fin <= r_a_fin;
            r_b_pt  <= r_a_pt;
            for (int k = 0; k < 4; k++) begin
                r_b_ext[k] <= r_a_ext[k];
                r_b_lhs[k] <= n_b_lhs[k];
                r_b_rhs[k] <= n_b_rhs[k];
            end
        end
        if (o_load_ok) begin
            r_o_fin <= r_b_fin;
            r_o_pt  <= r_b_pt;
            for (int k = 0; k < 4; k++) begin
                r_o_ext[k] <= r_b_ext[k];
            end
        end
    end

    // Drive the result: surviving point or the current extreme
    assign o_pt          = r_o_fin ? r_o_ext[r_o_idx] : r_o_pt;
    assign o_out_valid   = r_o_valid;
    assign o_qx          = o_pt.x;
    assign o_qy          = o_pt.y;
    assign o_is_extreme  = r_o_fin;
    assign o_last_result = r_o_fin && (r_o_idx == EXT_LAST);

    // A finish leaves the store empty
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_action == ACT_FINISH)) |=> !r_seen_any)
        else $error("seen flag survives a finish");

    // Extreme beats past the first belong to a live finish
    a_idx_in_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_idx != 2'd0) |-> (r_o_valid && r_o_fin))
        else $error("beat counter outside a finish");

    // A beat counter only moves on an output transfer
    a_idx_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_out_ready) |=> ($stable(r_o_idx) && r_o_valid))
        else $error("result changed while stalled");

    // The last extreme is always an extreme
    a_last_is_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_result |-> (o_is_extreme && o_out_valid))
        else $error("last flag on a filtered point");

endmodule
